// ===== src/keyframe_bracket_search_macros.svh =====
// Assertion macros shared by the checker of keyframe_bracket_search.
// Depends on nothing; the asserting scope provides clk and arst_n.
`ifndef KEYFRAME_BRACKET_SEARCH_MACROS_SVH
`define KEYFRAME_BRACKET_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define KBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define KBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/kbs_pkg.sv =====
// Package for keyframe_bracket_search: payload structs, constants, read-select
// codes and the command/status structs between controller and datapath.
// Depends on nothing.
package kbs_pkg;

	localparam int MAX_KEYS   = 256;
	localparam int KEY_W      = 8;
	localparam int TIME_W     = 16;
	localparam int FRAC_W     = 16;
	localparam int NUM_KEYS_W = 9;
	localparam int DIV_STEPS  = FRAC_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [NUM_KEYS_W-1:0] NUM_KEYS_RST = NUM_KEYS_W'(1);
	localparam logic [FRAC_W-1:0]     FRAC_MAX     = FRAC_W'(65535);

	// Input item modes
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// Register index (word address bit of paddr)
	localparam logic REG_NUM_KEYS = 1'b0;

	// Table read address select
	localparam logic [1:0] RD_SEL_ZERO  = 2'd0;
	localparam logic [1:0] RD_SEL_LAST  = 2'd1;
	localparam logic [1:0] RD_SEL_CUR   = 2'd2;
	localparam logic [1:0] RD_SEL_PROBE = 2'd3;

	typedef struct packed {
		logic              mode;
		logic [KEY_W-1:0]  key_index;
		logic [TIME_W-1:0] key_time;
		logic [TIME_W-1:0] anim_time;
		logic [KEY_W-1:0]  current_key_hint;
	} kbs_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]  current_key;
		logic [KEY_W-1:0]  lerp_from;
		logic [KEY_W-1:0]  lerp_to;
		logic [FRAC_W-1:0] fraction;
	} kbs_result_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       wr_en;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cap_k0;
		logic       cap_klast;
		logic       chk;
		logic       probe_end;
		logic       probe_chk;
		logic       div_set;
		logic       div_step;
		logic       finish;
	} kbs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic early;
		logic probe_at_end;
		logic probe_go;
		logic frac_trivial;
		logic div_last;
	} kbs_stat_t;

endpackage

// ===== src/keyframe_bracket_search.sv =====
// keyframe_bracket_search: finds the keyframe pair around an animation time.
//
// Channels: an item is taken on start while busy is low. Mode write stores
// key_time at key_index; mode lookup searches the table from the hint and
// returns one result, shown on result for exactly one cycle with done high.
// The receiver cannot hold a result off. Writes give no result.
// Configuration: APB register num_keys at byte address 0; pready is tied high.
// Sequence: a write keeps busy high while the key time is stored. A lookup
// reads key 0, the last key and the hint key and checks the bounds, then
// walks key by key, one table read and one compare per probed key, until
// the walk stops on a probed key or at the end of the table; it then sets
// up the fraction, runs the divider (one quotient bit per cycle) and loads
// the result. A zero or saturated fraction skips the divider; a time pinned
// to a bound or equal to the hint key skips the walk and the divider.
// The single read port of the key table and the serial divider set the
// length of a lookup; items are handled one at a time.
// Reset: arst_n clears the sequencer and sets num_keys to 1. The key table
// has no reset; entries read before they are written give undefined results.
module keyframe_bracket_search import kbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  kbs_item_t          item,
	output logic               busy,
	output logic               done,
	output kbs_result_t        result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [NUM_KEYS_W-1:0] num_keys_q;
	logic                  reg_wr;
	kbs_cmd_t              cmd;
	kbs_stat_t             stat;

	// Configuration register
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_NUM_KEYS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_keys_q <= NUM_KEYS_RST;
		end else if (reg_wr) begin
			num_keys_q <= pwdata[NUM_KEYS_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_NUM_KEYS && paddr[1:0] == 2'b00)
		? PDATA_W'(num_keys_q) : '0;

	kbs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (item.mode),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	kbs_dpath u_dpath (
		.clk     (clk),
		.item    (item),
		.num_keys(num_keys_q),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule

// ===== src/kbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/kbs_ctrl.sv =====
// Sequencer of keyframe_bracket_search: steps table writes, bound reads,
// the key walk and the serial division. Depends on kbs_pkg.
module kbs_ctrl import kbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      mode,
	input  kbs_stat_t stat,
	output kbs_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WRITE = 4'd1;
	localparam logic [3:0] S_RD0   = 4'd2;
	localparam logic [3:0] S_RDL   = 4'd3;
	localparam logic [3:0] S_RDH   = 4'd4;
	localparam logic [3:0] S_CHK   = 4'd5;
	localparam logic [3:0] S_PROBE = 4'd6;
	localparam logic [3:0] S_PCHK  = 4'd7;
	localparam logic [3:0] S_DSET  = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       done_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (mode == MODE_WRITE) ? S_WRITE : S_RD0;
				end
			end
			S_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = S_IDLE;
			end
			S_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SEL_ZERO;
				state_d    = S_RDL;
			end
			S_RDL: begin
				cmd.cap_k0 = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SEL_LAST;
				state_d    = S_RDH;
			end
			S_RDH: begin
				cmd.cap_klast = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_SEL_CUR;
				state_d       = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				state_d = stat.early ? S_FIN : S_PROBE;
			end
			S_PROBE: begin
				if (stat.probe_at_end) begin
					cmd.probe_end = 1'b1;
					state_d       = S_DSET;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SEL_PROBE;
					state_d    = S_PCHK;
				end
			end
			S_PCHK: begin
				cmd.probe_chk = 1'b1;
				state_d       = stat.probe_go ? S_PROBE : S_DSET;
			end
			S_DSET: begin
				cmd.div_set = 1'b1;
				state_d     = stat.frac_trivial ? S_FIN : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== src/kbs_dpath.sv =====
// Datapath of keyframe_bracket_search: key time table, walk registers,
// bracket compares and a radix-2 restoring divider. Depends on kbs_pkg, kbs_ram.
module kbs_dpath import kbs_pkg::*; (
	input  logic                  clk,
	input  kbs_item_t             item,
	input  logic [NUM_KEYS_W-1:0] num_keys,
	input  kbs_cmd_t              cmd,
	output kbs_stat_t             stat,
	output kbs_result_t           result
);

	kbs_item_t         item_q;
	logic [KEY_W-1:0]  cur_q;
	logic [KEY_W-1:0]  probe_q;
	logic              fwd_q;
	logic [TIME_W-1:0] k0_q;
	logic [TIME_W-1:0] klast_q;
	logic [TIME_W-1:0] klo_q;
	logic [TIME_W-1:0] khi_q;
	logic [KEY_W-1:0]  from_q;
	logic [KEY_W-1:0]  to_q;
	logic [TIME_W-1:0] den_q;
	logic [TIME_W-1:0] rem_q;
	logic [FRAC_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	kbs_result_t       result_q;

	logic [KEY_W-1:0]  last;
	logic [KEY_W-1:0]  hint_clamped;
	logic [KEY_W-1:0]  raddr;
	logic [TIME_W-1:0] rdata;
	logic [TIME_W-1:0] t;
	logic              lo_bound;
	logic              hi_bound;
	logic              cur_eq;
	logic              cur_lt;
	logic [TIME_W-1:0] num;
	logic [TIME_W-1:0] den;
	logic              frac_zero;
	logic              frac_sat;
	logic [TIME_W:0]   rem_sh;
	logic              rem_ge;

	assign t = item_q.anim_time;

	// Last valid key, with out-of-range counts pinned
	always_comb begin
		if (num_keys == '0) begin
			last = '0;
		end else if (num_keys > NUM_KEYS_W'(MAX_KEYS)) begin
			last = KEY_W'(MAX_KEYS - 1);
		end else begin
			last = KEY_W'(num_keys - NUM_KEYS_W'(1));
		end
	end

	assign hint_clamped = (item.current_key_hint > last) ? last : item.current_key_hint;

	// Table read address
	always_comb begin
		case (cmd.rd_sel)
			RD_SEL_ZERO:  raddr = '0;
			RD_SEL_LAST:  raddr = last;
			RD_SEL_CUR:   raddr = cur_q;
			RD_SEL_PROBE: raddr = probe_q;
			default:      raddr = '0;
		endcase
	end

	kbs_ram #(
		.WIDTH(TIME_W),
		.DEPTH(MAX_KEYS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(item_q.key_index),
		.wdata(item_q.key_time),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Bracket compares
	assign lo_bound = (t <= k0_q);
	assign hi_bound = (klast_q <= t);
	assign cur_eq   = (rdata == t);
	assign cur_lt   = (rdata < t);

	// Fraction operands and trivial outcomes
	assign num       = t - klo_q;
	assign den       = khi_q - klo_q;
	assign frac_zero = (khi_q <= klo_q) || (t <= klo_q);
	assign frac_sat  = !frac_zero && (num >= den);

	// One quotient bit per step
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	always_comb begin
		stat.early        = lo_bound || hi_bound || cur_eq;
		stat.probe_at_end = fwd_q ? (probe_q == last) : (probe_q == '0);
		stat.probe_go     = fwd_q ? (rdata <= t) : (t <= rdata);
		stat.frac_trivial = frac_zero || frac_sat;
		stat.div_last     = (cnt_q == CNT_W'(DIV_STEPS - 1));
	end

	// Item capture and bound keys
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.cap_k0) begin
			k0_q <= rdata;
		end
		if (cmd.cap_klast) begin
			klast_q <= rdata;
		end
	end

	// Walk state: current key, probe, bracket times and indices
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= hint_clamped;
		end else if (cmd.chk) begin
			if (lo_bound) begin
				cur_q  <= '0;
				from_q <= '0;
				to_q   <= '0;
			end else if (hi_bound) begin
				cur_q  <= last;
				from_q <= last;
				to_q   <= last;
			end else if (cur_lt) begin
				klo_q   <= rdata;
				probe_q <= cur_q + KEY_W'(1);
				fwd_q   <= 1'b1;
			end else if (cur_eq) begin
				from_q <= cur_q;
				to_q   <= cur_q;
			end else begin
				khi_q   <= rdata;
				probe_q <= cur_q - KEY_W'(1);
				fwd_q   <= 1'b0;
			end
		end else if (cmd.probe_end) begin
			if (fwd_q) begin
				khi_q  <= klast_q;
				from_q <= cur_q;
				to_q   <= probe_q;
			end else begin
				klo_q  <= k0_q;
				from_q <= probe_q;
				to_q   <= cur_q;
			end
		end else if (cmd.probe_chk) begin
			if (stat.probe_go) begin
				cur_q <= probe_q;
				if (fwd_q) begin
					klo_q   <= rdata;
					probe_q <= probe_q + KEY_W'(1);
				end else begin
					khi_q   <= rdata;
					probe_q <= probe_q - KEY_W'(1);
				end
			end else if (fwd_q) begin
				khi_q  <= rdata;
				from_q <= cur_q;
				to_q   <= probe_q;
			end else begin
				klo_q  <= rdata;
				from_q <= probe_q;
				to_q   <= cur_q;
			end
		end
	end

	// Fraction: trivial outcomes or restoring division of num*2^16 by den
	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			quo_q <= '0;
		end else if (cmd.div_set) begin
			quo_q <= frac_sat ? FRAC_MAX : '0;
			rem_q <= num;
			den_q <= den;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
			rem_q <= rem_ge ? TIME_W'(rem_sh - {1'b0, den_q}) : rem_sh[TIME_W-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.current_key <= cur_q;
			result_q.lerp_from   <= from_q;
			result_q.lerp_to     <= to_q;
			result_q.fraction    <= quo_q;
		end
	end

	assign result = result_q;

endmodule

// ===== src/kbs_checker.sv =====
// Port-level checker for keyframe_bracket_search, bound to the top level.
// Depends on kbs_pkg and keyframe_bracket_search_macros.svh.
`include "keyframe_bracket_search_macros.svh"

module kbs_checker import kbs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input kbs_result_t result
);

	logic cur_on_end;
	logic pinned;

	assign cur_on_end = (result.current_key == result.lerp_from)
		|| (result.current_key == result.lerp_to);
	assign pinned     = (result.lerp_from == result.lerp_to);

	// A result only ends a transaction that was in flight
	`KBS_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a transaction in flight")

	// The bracket never runs backward
	`KBS_ASSERT_NOW(a_bracket_order, done, result.lerp_from <= result.lerp_to, "lerp_from above lerp_to")

	// The current key is one end of the bracket
	`KBS_ASSERT_NOW(a_cur_in_bracket, done, cur_on_end, "current_key outside the bracket")

	// A collapsed bracket has zero weight
	`KBS_ASSERT_NOW(a_pinned_zero, done && pinned, result.fraction == '0, "nonzero fraction on one key")

	// No result in the cycle after an accepted transaction
	`KBS_ASSERT_NEXT(a_no_early_result, start && !busy, !done, "result too soon after acceptance")

endmodule

bind keyframe_bracket_search kbs_checker u_kbs_checker (.*);
